FILE: rtl/adaptive_stall_detector_assert.svh
// assertion macros shared by the stall detector rtl
// no dependencies; include with the bare file name inside a module body
`ifndef ADAPTIVE_STALL_DETECTOR_ASSERT_SVH
`define ADAPTIVE_STALL_DETECTOR_ASSERT_SVH

// condition holds at every clock edge outside reset
`define ASD_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// same-cycle implication
`define ASD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/asd_pkg.sv
// types, constants and register codes for the adaptive stall detector
// no dependencies
package asd_pkg;

    localparam int LOAD_W     = 10;
    localparam int VEL_W      = 24;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 23;
    localparam int MARGIN_W   = 10;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 8;
    localparam int Q_SHIFT    = 16;
    localparam int BASE_W     = LOAD_W + Q_SHIFT;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_INDEX_W = 2;

    localparam logic [VEL_W-1:0]    SPEED_FLOOR    = 24'd500;
    localparam logic [VEL_W:0]      SPEED_SLACK    = 25'd100;
    localparam logic [MARGIN_W-1:0] DEFAULT_MARGIN = 10'd30;
    localparam logic [COUNT_W-1:0]  COUNT_MAX      = 8'd255;

    localparam logic [SPEED_W-1:0]  TARGET_SPEED_RST = 23'd0;
    localparam logic [MARGIN_W-1:0] STALL_MARGIN_RST = 10'd0;
    localparam logic [DELAY_W-1:0]  SETTLE_DELAY_RST = 16'd500;
    localparam logic [COUNT_W-1:0]  STALL_LIMIT_RST  = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_SPEED = 2'd0,
        REG_STALL_MARGIN = 2'd1,
        REG_SETTLE_DELAY = 2'd2,
        REG_STALL_LIMIT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  target_speed;
        logic [MARGIN_W-1:0] stall_margin;
        logic [DELAY_W-1:0]  settle_delay_ms;
        logic [COUNT_W-1:0]  stall_limit;
    } cfg_t;

    typedef struct packed {
        logic [BASE_W-1:0]  baseline;
        logic [COUNT_W-1:0] stall_errors;
        logic [TIME_W-1:0]  settle_start;
        logic               baseline_valid;
    } state_t;

    typedef struct packed {
        logic               stop_request;
        logic [COUNT_W-1:0] fault_count;
        logic               armed;
        logic [LOAD_W-1:0]  baseline_level;
    } result_t;

endpackage

FILE: rtl/asd_cfg.sv
// configuration registers of the stall detector, plain write port
// depends on asd_pkg
module asd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [asd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output asd_pkg::cfg_t                  cfg
);
    import asd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_TARGET_SPEED: cfg_next.target_speed = cfg_wr_data[SPEED_W-1:0];
                REG_STALL_MARGIN: cfg_next.stall_margin = cfg_wr_data[MARGIN_W-1:0];
                REG_SETTLE_DELAY: cfg_next.settle_delay_ms = cfg_wr_data[DELAY_W-1:0];
                REG_STALL_LIMIT:  cfg_next.stall_limit = cfg_wr_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed    <= TARGET_SPEED_RST;
            cfg_reg.stall_margin    <= STALL_MARGIN_RST;
            cfg_reg.settle_delay_ms <= SETTLE_DELAY_RST;
            cfg_reg.stall_limit     <= STALL_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/asd_update.sv
// per-sample update: at-speed check, settle timer, stall test and baseline average
// depends on asd_pkg; purely combinational
module asd_update (
    input  asd_pkg::cfg_t                    cfg,
    input  asd_pkg::state_t                  state_cur,
    input  logic [asd_pkg::LOAD_W-1:0]       load_value,
    input  logic signed [asd_pkg::VEL_W-1:0] actual_velocity,
    input  logic [asd_pkg::TIME_W-1:0]       now_ms,
    output asd_pkg::state_t                  state_upd,
    output asd_pkg::result_t                 result
);
    import asd_pkg::*;

    // floor(y/5) == (y * RECIP5) >> 31 for every y below 2^29
    localparam int          Y_W    = BASE_W + 3;
    localparam logic [Y_W-1:0] RECIP5 = 29'd429496730;

    logic [VEL_W-1:0]    vel_raw;
    logic [VEL_W-1:0]    mag;
    logic                at_speed;
    logic [TIME_W-1:0]   elapsed;
    logic                settled;
    logic [MARGIN_W-1:0] margin;
    logic [LOAD_W:0]     thresh;
    logic [BASE_W-1:0]   sample_q;
    logic [BASE_W-1:0]   base_eff;
    logic [COUNT_W-1:0]  err_eff;
    logic                is_stall;
    logic [BASE_W+4:0]   wsum;
    logic [Y_W-1:0]      wsum_q4;
    logic [2*Y_W-1:0]    prod;
    logic [BASE_W-1:0]   base_avg;
    logic [COUNT_W-1:0]  err_step;
    logic                stop;

    always_comb begin
        vel_raw  = $unsigned(actual_velocity);
        mag      = vel_raw[VEL_W-1] ? (~vel_raw + 1'b1) : vel_raw;
        at_speed = (mag > SPEED_FLOOR) &&
                   ({1'b0, mag} + SPEED_SLACK >= {2'b00, cfg.target_speed});

        elapsed  = now_ms - state_cur.settle_start;
        settled  = elapsed > {{(TIME_W-DELAY_W){1'b0}}, cfg.settle_delay_ms};

        margin   = (cfg.stall_margin == '0) ? DEFAULT_MARGIN : cfg.stall_margin;
        sample_q = {load_value, {Q_SHIFT{1'b0}}};

        // first settled sample seeds the baseline
        base_eff = state_cur.baseline_valid ? state_cur.baseline : sample_q;
        err_eff  = state_cur.baseline_valid ? state_cur.stall_errors : '0;

        thresh   = {1'b0, load_value} + {1'b0, margin};
        is_stall = {thresh, {Q_SHIFT{1'b0}}} < {1'b0, base_eff};

        // 19*b + sample, then /4 by shift and /5 by reciprocal
        wsum     = ({5'b0, base_eff} << 4) + ({5'b0, base_eff} << 1) +
                   {5'b0, base_eff} + {5'b0, sample_q};
        wsum_q4  = wsum[BASE_W+4:2];
        prod     = {{Y_W{1'b0}}, wsum_q4} * {{Y_W{1'b0}}, RECIP5};
        base_avg = prod[31+BASE_W-1:31];

        if (is_stall) begin
            err_step = (err_eff == COUNT_MAX) ? err_eff : err_eff + 1'b1;
        end else begin
            err_step = (err_eff == '0) ? err_eff : err_eff - 1'b1;
        end
        stop = err_step >= cfg.stall_limit;

        state_upd = state_cur;
        result.stop_request = 1'b0;
        if (!at_speed) begin
            state_upd.settle_start   = now_ms;
            state_upd.stall_errors   = '0;
            state_upd.baseline_valid = 1'b0;
            state_upd.baseline       = '0;
        end else if (settled) begin
            state_upd.baseline_valid = 1'b1;
            state_upd.baseline       = is_stall ? base_eff : base_avg;
            state_upd.stall_errors   = stop ? '0 : err_step;
            result.stop_request      = stop;
        end
        result.fault_count    = state_upd.stall_errors;
        result.armed          = state_upd.baseline_valid;
        result.baseline_level = state_upd.baseline[BASE_W-1:Q_SHIFT];
    end

endmodule

FILE: rtl/adaptive_stall_detector.sv
// adaptive stall detector top level: input register, update logic, result register
// depends on asd_pkg, asd_cfg, asd_update and adaptive_stall_detector_assert.svh
//
// Takes one load/velocity sample per clock while the output side is not stalled and
// returns one result word per sample. Each word passes an input register and a
// result register, and its result is written to the result register as it leaves
// the input register; throughput is one sample per cycle while the output side is
// not stalled, set by the combinational state update loop (baseline average with a
// constant-reciprocal divide by 20). The result register lets a new sample enter
// while the previous result still waits to be taken.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data into the
// asd_cfg registers; write it only while no sample is in flight.
module adaptive_stall_detector (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [asd_pkg::LOAD_W-1:0]       s_load_value,
    input  logic signed [asd_pkg::VEL_W-1:0] s_actual_velocity,
    input  logic [asd_pkg::TIME_W-1:0]       s_now_ms,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_stop_request,
    output logic [asd_pkg::COUNT_W-1:0]      m_fault_count,
    output logic                             m_armed,
    output logic [asd_pkg::LOAD_W-1:0]       m_baseline_level,

    input  logic                             cfg_wr_en,
    input  logic [asd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import asd_pkg::*;
    `include "adaptive_stall_detector_assert.svh"

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    state_t  state_upd;
    result_t result;
    result_t res_reg;

    logic                     in_valid_reg;
    logic [LOAD_W-1:0]        load_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     m_valid_reg;
    logic                     fire;

    asd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    asd_update u_update (
        .cfg             (cfg),
        .state_cur       (state_reg),
        .load_value      (load_reg),
        .actual_velocity (vel_reg),
        .now_ms          (now_reg),
        .state_upd       (state_upd),
        .result          (result)
    );

    // a word moves from the input register to the result register
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        state_next = fire ? state_upd : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            load_reg <= s_load_value;
            vel_reg  <= s_actual_velocity;
            now_reg  <= s_now_ms;
        end
        if (fire) begin
            res_reg <= result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_stop_request   = res_reg.stop_request;
    assign m_fault_count    = res_reg.fault_count;
    assign m_armed          = res_reg.armed;
    assign m_baseline_level = res_reg.baseline_level;

    `ASD_ASSERT_IMP(a_stop_clears_count, aclk, aresetn, m_valid_reg && m_stop_request, m_fault_count == '0 && m_armed, "stop request without armed state and cleared count")
    `ASD_ASSERT_HOLDS(a_disarmed_is_clear, aclk, aresetn, state_reg.baseline_valid || (state_reg.baseline == '0 && state_reg.stall_errors == '0), "disarmed state holds a baseline or a count")
    `ASD_ASSERT_NXT(a_fire_fills_output, aclk, aresetn, fire, m_valid_reg, "processed word did not reach the result register")
    `ASD_ASSERT_NXT(a_state_frozen_idle, aclk, aresetn, !fire, state_reg == $past(state_reg), "detector state changed without a word")

endmodule
